### rtl/smfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfg_pkg: shared definitions for the seeded memory fill generator
// operation and fill mode codes, generator constants, shift amounts
// ----------------------------------------------------------------------------
package smfg_pkg;

  // operation codes of an input request
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // fill mode register codes, the unused code fills with zeros
  localparam logic [1:0] FILL_ONES   = 2'd0;
  localparam logic [1:0] FILL_ZEROS  = 2'd1;
  localparam logic [1:0] FILL_RANDOM = 2'd2;
  localparam logic [1:0] FILL_UNUSED = 2'd3;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_ONE  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94d049bb133111eb;

  localparam int MIX_SHIFT_ONE   = 30;
  localparam int MIX_SHIFT_TWO   = 27;
  localparam int MIX_SHIFT_THREE = 31;

  // xoroshiro128+ rotate and shift amounts
  localparam int ROT_A   = 55;
  localparam int ROT_B   = 36;
  localparam int SHIFT_B = 14;

  // finalizer round index, three xor-shift rounds with two multiplies between
  typedef logic [1:0] mix_round_t;
  localparam mix_round_t ROUND_FIRST = 2'd0;
  localparam mix_round_t ROUND_LAST  = 2'd2;

  // request to and answer from the finalizer unit
  typedef struct packed {
    logic        start;
    logic [63:0] z;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] z;
  } mix_rsp_t;

endpackage

### rtl/smfg_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfg_mix: iterative splitmix64 finalizer
// one shared 32x32 multiplier builds each 64-bit modular product from three
// partial products; a small sequencer steps the xor-shift and multiply rounds
// ----------------------------------------------------------------------------
module smfg_mix
  import smfg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mix_req_t req,
  output mix_rsp_t rsp
);

  typedef enum logic [4:0] {
    M_IDLE   = 5'b00001,
    M_XOR    = 5'b00010,
    M_MUL_LL = 5'b00100,
    M_MUL_LH = 5'b01000,
    M_MUL_HL = 5'b10000
  } mix_state_t;

  mix_state_t  state;
  mix_state_t  state_next;
  mix_round_t  round;
  logic        done;
  logic [63:0] z;
  logic [63:0] acc;

  logic [63:0] mul_const;
  logic [63:0] z_shifted;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // round dependent constant and shift
  always_comb begin
    case (round)
      ROUND_FIRST: begin
        mul_const = MIX_MUL_ONE;
        z_shifted = z >> MIX_SHIFT_ONE;
      end
      2'd1: begin
        mul_const = MIX_MUL_TWO;
        z_shifted = z >> MIX_SHIFT_TWO;
      end
      default: begin
        mul_const = MIX_MUL_TWO;
        z_shifted = z >> MIX_SHIFT_THREE;
      end
    endcase
  end

  // shared multiplier operand select
  assign op_a = (state == M_MUL_HL) ? z[63:32] : z[31:0];
  assign op_b = (state == M_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
  assign prod = {32'd0, op_a} * {32'd0, op_b};

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: begin
        if (req.start) state_next = M_XOR;
      end
      M_XOR: begin
        state_next = (round == ROUND_LAST) ? M_IDLE : M_MUL_LL;
      end
      M_MUL_LL: state_next = M_MUL_LH;
      M_MUL_LH: state_next = M_MUL_HL;
      M_MUL_HL: state_next = M_XOR;
      default:  state_next = M_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      round <= ROUND_FIRST;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == M_XOR) && (round == ROUND_LAST);
      if (state == M_IDLE && req.start) begin
        round <= ROUND_FIRST;
      end else if (state == M_MUL_HL) begin
        round <= round + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) z <= req.z;
      end
      M_XOR:    z <= z ^ z_shifted;
      M_MUL_LL: acc <= prod;
      M_MUL_LH: acc[63:32] <= acc[63:32] + prod[31:0];
      M_MUL_HL: z <= {acc[63:32] + prod[31:0], acc[31:0]};
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.z    = z;

  // done is a single pulse, seen with the unit back at rest
  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("finalizer done held longer than one cycle");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> (state == M_IDLE))
    else $error("finalizer done while still running");

endmodule

### rtl/seeded_memory_fill_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_memory_fill_generator: power-on memory fill byte source
// xoroshiro128+ generator seeded through two splitmix64 rounds
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries operation, seed, last_of_fill.
//   a fill request gives one result on out_valid / out_stall: fill_byte,
//   random_word and last. a reseed request gives no result. fill_mode is
//   written via write_enable / write_data only while idle, the user's duty.
// timing:
//   a fill request's result is registered and shows in the cycle after the
//   request, and a fill request may follow every cycle while out_stall is low.
//   a reseed keeps in_stall high after it is taken until both words are
//   loaded: two finalizer passes on the shared 32x32 multiplier (three
//   partial products per 64-bit multiply), each with a handover of its result.
// reset:
//   rst clears the generator words to zero, fill_mode to 0xFF mode and the
//   output register to empty. random mode before a reseed gives zero bytes.
// stall:
//   the result register holds while out_stall is high; in_stall is then high
//   too. a new request is taken in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
module seeded_memory_fill_generator
  import smfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] seed,
  input  logic        last_of_fill,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  fill_byte,
  output logic [63:0] random_word,
  output logic        last
);

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_MIX_A = 3'b010,
    T_MIX_B = 3'b100
  } top_state_t;

  top_state_t  state;
  logic [1:0]  fill_mode;
  logic [63:0] gen_word_a;
  logic [63:0] gen_word_b;
  logic [63:0] seed_x;

  logic        accept;
  logic        accept_fill;
  logic        accept_seed;
  logic [63:0] seed_sum;
  logic [63:0] rnd_sum;
  logic [63:0] b_mixed;
  logic [63:0] a_next;
  logic [63:0] b_next;

  mix_req_t mix_req;
  mix_rsp_t mix_rsp;

  // request handshake
  assign in_stall    = (state != T_IDLE) || (out_valid && out_stall);
  assign accept      = in_valid && !in_stall;
  assign accept_fill = accept && (operation == OP_FILL);
  assign accept_seed = accept && (operation == OP_RESEED);

  // seed expansion start value
  assign seed_sum = {32'd0, seed} + GOLDEN_GAMMA;

  // finalizer requests: first word from the seed, second one gamma later
  assign mix_req.start = accept_seed || ((state == T_MIX_A) && mix_rsp.done);
  assign mix_req.z     = (state == T_IDLE) ? seed_sum : seed_x + GOLDEN_GAMMA;

  smfg_mix u_mix (
    .clk (clk),
    .rst (rst),
    .req (mix_req),
    .rsp (mix_rsp)
  );

  // xoroshiro128+ output and step
  assign rnd_sum = gen_word_a + gen_word_b;
  assign b_mixed = gen_word_b ^ gen_word_a;
  assign a_next  = {gen_word_a[63-ROT_A:0], gen_word_a[63:64-ROT_A]}
                   ^ b_mixed ^ (b_mixed << SHIFT_B);
  assign b_next  = {b_mixed[63-ROT_B:0], b_mixed[63:64-ROT_B]};

  // sequencer, mode register and generator words
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      fill_mode  <= FILL_ONES;
      gen_word_a <= 64'd0;
      gen_word_b <= 64'd0;
    end else begin
      if (write_enable) fill_mode <= write_data;
      case (state)
        T_IDLE: begin
          if (accept_seed) begin
            state <= T_MIX_A;
          end else if (accept_fill && fill_mode == FILL_RANDOM) begin
            gen_word_a <= a_next;
            gen_word_b <= b_next;
          end
        end
        T_MIX_A: begin
          if (mix_rsp.done) begin
            gen_word_a <= mix_rsp.z;
            state      <= T_MIX_B;
          end
        end
        T_MIX_B: begin
          if (mix_rsp.done) begin
            gen_word_b <= mix_rsp.z;
            state      <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // seed chain value kept for the second word
  always_ff @(posedge clk) begin
    if (accept_seed) seed_x <= seed_sum;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_fill) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept_fill) begin
      last <= last_of_fill;
      case (fill_mode)
        FILL_ONES: begin
          fill_byte   <= BYTE_ONES;
          random_word <= 64'd0;
        end
        FILL_RANDOM: begin
          fill_byte   <= rnd_sum[7:0];
          random_word <= rnd_sum;
        end
        default: begin
          fill_byte   <= BYTE_ZEROS;
          random_word <= 64'd0;
        end
      endcase
    end
  end

  // a reseed occupies the block until both words are loaded
  a_seed_busy : assert property (@(posedge clk) disable iff (rst)
    accept_seed |=> (state == T_MIX_A) && in_stall)
    else $error("reseed request did not start the seed expansion");

  // a fill request yields a result carrying its end mark
  a_fill_result : assert property (@(posedge clk) disable iff (rst)
    accept_fill |=> out_valid && (last == $past(last_of_fill)))
    else $error("fill request lost or end mark not echoed");

  // fixed modes leave the word at zero
  a_fixed_zero : assert property (@(posedge clk) disable iff (rst)
    (accept_fill && fill_mode != FILL_RANDOM) |=> (random_word == 64'd0))
    else $error("random word nonzero in a fixed mode");

  // finalizer answers only during seed expansion
  a_done_state : assert property (@(posedge clk) disable iff (rst)
    mix_rsp.done |-> (state == T_MIX_A || state == T_MIX_B))
    else $error("finalizer answer outside seed expansion");

endmodule

### verif/seeded_memory_fill_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_memory_fill_generator_test: self-checking bench for the fill generator
// a queue-fed driver sends reseed and fill requests with random gaps, a
// monitor stalls the result side at random and checks each result against
// a bit-exact xoroshiro128+ / splitmix64 predictor run at request acceptance
// ----------------------------------------------------------------------------
module seeded_memory_fill_generator_test
  import smfg_pkg::*;
();

  localparam int SETTLE_CYCLES = 25;

  typedef struct {
    logic        operation;
    logic [31:0] seed;
    logic        last_of_fill;
  } fill_req_t;

  typedef struct {
    logic [7:0]  fill_byte;
    logic [63:0] random_word;
    logic        last;
  } fill_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_enable = 1'b0;
  logic [1:0]  write_data = FILL_ONES;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_RESEED;
  logic [31:0] seed = 32'd0;
  logic        last_of_fill = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  fill_byte;
  logic [63:0] random_word;
  logic        last;

  fill_req_t    pending_reqs[$];
  fill_result_t fill_results_due[$];

  // shadow of the generator and the mode register
  logic [63:0] gen_a = 64'd0;
  logic [63:0] gen_b = 64'd0;
  logic [1:0]  mode_shadow = FILL_ONES;

  bit failed = 1'b0;
  int gap_left = 0;
  int quiet_in = 0;
  int stall_left = 0;
  int quiet_out = 0;

  seeded_memory_fill_generator dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .seed         (seed),
    .last_of_fill (last_of_fill),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fill_byte    (fill_byte),
    .random_word  (random_word),
    .last         (last)
  );

  always #5 clk = ~clk;

  // splitmix64 finalizer
  function automatic logic [63:0] splitmix_finish(input logic [63:0] z);
    z = (z ^ (z >> MIX_SHIFT_ONE)) * MIX_MUL_ONE;
    z = (z ^ (z >> MIX_SHIFT_TWO)) * MIX_MUL_TWO;
    return z ^ (z >> MIX_SHIFT_THREE);
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  // expected outcome of one accepted request, updates the shadow generator
  task automatic predict_fill(input fill_req_t req);
    fill_result_t res;
    logic [63:0]  x;
    logic [63:0]  mixed_b;
    if (req.operation == OP_RESEED) begin
      x = {32'd0, req.seed} + GOLDEN_GAMMA;
      gen_a = splitmix_finish(x);
      gen_b = splitmix_finish(x + GOLDEN_GAMMA);
    end else begin
      res.random_word = 64'd0;
      res.last = req.last_of_fill;
      case (mode_shadow)
        FILL_ONES: begin
          res.fill_byte = BYTE_ONES;
        end
        FILL_RANDOM: begin
          res.random_word = gen_a + gen_b;
          res.fill_byte = res.random_word[7:0];
          mixed_b = gen_b ^ gen_a;
          gen_a = rotl64(gen_a, ROT_A) ^ mixed_b ^ (mixed_b << SHIFT_B);
          gen_b = rotl64(mixed_b, ROT_B);
        end
        // zeros mode and the unused code both give zero bytes
        default: begin
          res.fill_byte = BYTE_ZEROS;
        end
      endcase
      fill_results_due.push_back(res);
    end
  endtask

  // mostly short pauses, a few long ones, and now and then a stretch of none
  function automatic int next_pause(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk) begin
    logic      next_valid;
    fill_req_t req;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req.operation = operation;
        req.seed = seed;
        req.last_of_fill = last_of_fill;
        predict_fill(req);
        next_valid = 1'b0;
        gap_left = next_pause(quiet_in);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          operation <= req.operation;
          seed <= req.seed;
          last_of_fill <= req.last_of_fill;
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // result monitor and stall source
  always @(posedge clk) begin
    fill_result_t due;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (fill_results_due.size() == 0) begin
          $error("unexpected result: fill_byte %h random_word %h last %b",
                 fill_byte, random_word, last);
          failed = 1'b1;
        end else begin
          due = fill_results_due.pop_front();
          if (fill_byte !== due.fill_byte) begin
            $error("fill_byte: expected %h, actual %h", due.fill_byte, fill_byte);
            failed = 1'b1;
          end
          if (random_word !== due.random_word) begin
            $error("random_word: expected %h, actual %h", due.random_word, random_word);
            failed = 1'b1;
          end
          if (last !== due.last) begin
            $error("last: expected %b, actual %b", due.last, last);
            failed = 1'b1;
          end
        end
      end
      if (stall_left == 0) stall_left = next_pause(quiet_out);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_req(input logic op, input logic [31:0] s, input logic lst);
    fill_req_t req;
    req.operation = op;
    req.seed = s;
    req.last_of_fill = lst;
    pending_reqs.push_back(req);
  endtask

  // wait until every request is taken and every result is back, then settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || fill_results_due.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    @(posedge clk);
    write_enable <= 1'b1;
    write_data <= m;
    @(posedge clk);
    write_enable <= 1'b0;
    mode_shadow = m;
  endtask

  // stimulus
  initial begin
    int          count;
    int          run_len;
    logic [1:0]  m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // random mode before any reseed gives zero bytes
    write_mode(FILL_RANDOM);
    queue_req(OP_FILL, 32'hFFFFFFFF, 1'b0);
    queue_req(OP_FILL, 32'h00000000, 1'b1);
    // seed extremes, last_of_fill ignored on reseed
    queue_req(OP_RESEED, 32'h00000000, 1'b1);
    queue_req(OP_FILL, 32'h00000000, 1'b0);
    queue_req(OP_FILL, 32'h00000000, 1'b0);
    queue_req(OP_FILL, 32'h00000000, 1'b1);
    queue_req(OP_RESEED, 32'hFFFFFFFF, 1'b0);
    queue_req(OP_FILL, 32'hFFFFFFFF, 1'b0);
    queue_req(OP_FILL, 32'hFFFFFFFF, 1'b1);
    queue_req(OP_RESEED, 32'h80000001, 1'b0);
    queue_req(OP_RESEED, 32'h7FFFFFFE, 1'b1);
    queue_req(OP_FILL, 32'h5A5A5A5A, 1'b1);
    // fixed modes leave the generator alone
    write_mode(FILL_ONES);
    queue_req(OP_FILL, 32'hFFFFFFFF, 1'b0);
    queue_req(OP_FILL, 32'h00000000, 1'b1);
    write_mode(FILL_ZEROS);
    queue_req(OP_FILL, 32'h12345678, 1'b0);
    queue_req(OP_FILL, 32'h87654321, 1'b1);
    // unused mode code behaves as zeros
    write_mode(FILL_UNUSED);
    queue_req(OP_FILL, 32'hFFFFFFFF, 1'b0);
    queue_req(OP_FILL, 32'h00000000, 1'b1);
    write_mode(FILL_RANDOM);
    queue_req(OP_FILL, 32'h0, 1'b0);
    queue_req(OP_FILL, 32'h0, 1'b1);
    // reseed in a fixed mode still reloads the words
    write_mode(FILL_ONES);
    queue_req(OP_RESEED, 32'hDEADBEEF, 1'b0);
    queue_req(OP_FILL, 32'h0, 1'b1);
    write_mode(FILL_RANDOM);
    queue_req(OP_FILL, 32'h0, 1'b0);
    queue_req(OP_FILL, 32'h0, 1'b1);

    // random phases, mostly reseed followed by a fill run
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0: m = FILL_ONES;
        1: m = FILL_ZEROS;
        2: m = FILL_UNUSED;
        default: m = FILL_RANDOM;
      endcase
      write_mode(m);
      count = 0;
      while (count < 105) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_req(OP_RESEED, $urandom, 1'($urandom_range(0, 1)));
          run_len = $urandom_range(1, 20);
          for (int i = 0; i < run_len; i++)
            queue_req(OP_FILL, $urandom, i == run_len - 1);
          count += run_len + 1;
        end else begin
          queue_req(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
          count++;
        end
      end
    end

    wait_drained();
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
